>>> hdl/tcpq_pkg.sv
// Shared types and codes for the three-class strict priority queue.
`default_nettype none

package tcpq_pkg;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CLASS_A   = 2'd0,
    CLASS_B   = 2'd1,
    CLASS_C   = 2'd2,
    CLASS_BAD = 2'd3
  } class_e;

  typedef enum logic [2:0] {
    ST_ENQUEUED  = 3'd0,
    ST_DEQUEUED  = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD_CLASS = 3'd4
  } status_e;

  localparam int unsigned ClassCount = 3;

  // Per-request decision handed from the control to the store and result stage.
  typedef struct packed {
    logic    wr_en;
    logic    rd_en;
    class_e  sel_cls;
    status_e status;
  } ctrl_t;

endpackage

`default_nettype wire

>>> hdl/tcpq_ctrl.sv
// Head, tail and fill counters per class, and the strict priority decision.
`default_nettype none

module tcpq_ctrl #(
  parameter int unsigned QUEUE_DEPTH = 16,
  localparam int unsigned IW = $clog2(QUEUE_DEPTH),
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            fire_i,
  input  wire tcpq_pkg::op_e   op_i,
  input  wire logic [1:0]      cls_i,
  output tcpq_pkg::ctrl_t      ctl_o,
  output logic [IW-1:0]        waddr_o,
  output logic [IW-1:0]        raddr_o
);
  import tcpq_pkg::*;

  logic [IW-1:0] head_q  [ClassCount];
  logic [IW-1:0] tail_q  [ClassCount];
  logic [CW-1:0] count_q [ClassCount];
  logic [ClassCount-1:0] nonempty;
  logic [ClassCount-1:0] full;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] ptr);
    return (ptr == IW'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  always_comb begin
    for (int c = 0; c < ClassCount; c++) begin
      nonempty[c] = (count_q[c] != '0);
      full[c]     = (count_q[c] == CW'(QUEUE_DEPTH));
    end
  end

  always_comb begin
    ctl_o   = '{wr_en: 1'b0, rd_en: 1'b0, sel_cls: CLASS_A, status: ST_EMPTY};
    waddr_o = '0;
    raddr_o = '0;
    if (op_i == OP_ENQUEUE) begin
      unique case (cls_i) inside
        CLASS_A, CLASS_B, CLASS_C: begin
          if (full[cls_i]) begin
            ctl_o.status = ST_FULL;
          end else begin
            ctl_o.status  = ST_ENQUEUED;
            ctl_o.wr_en   = fire_i;
            ctl_o.sel_cls = class_e'(cls_i);
            waddr_o       = tail_q[cls_i];
          end
        end
        default: ctl_o.status = ST_BAD_CLASS;
      endcase
    end else begin
      // served_class stays A unless a tag is actually removed
      if (nonempty[CLASS_A]) begin
        ctl_o.sel_cls = CLASS_A;
      end else if (nonempty[CLASS_B]) begin
        ctl_o.sel_cls = CLASS_B;
      end else if (nonempty[CLASS_C]) begin
        ctl_o.sel_cls = CLASS_C;
      end
      if (nonempty != '0) begin
        ctl_o.status = ST_DEQUEUED;
        ctl_o.rd_en  = fire_i;
        raddr_o      = head_q[ctl_o.sel_cls];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < ClassCount; c++) begin
        head_q[c]  <= '0;
        tail_q[c]  <= '0;
        count_q[c] <= '0;
      end
    end else begin
      if (ctl_o.wr_en) begin
        tail_q[ctl_o.sel_cls]  <= wrap_inc(tail_q[ctl_o.sel_cls]);
        count_q[ctl_o.sel_cls] <= count_q[ctl_o.sel_cls] + 1'b1;
      end
      if (ctl_o.rd_en) begin
        head_q[ctl_o.sel_cls]  <= wrap_inc(head_q[ctl_o.sel_cls]);
        count_q[ctl_o.sel_cls] <= count_q[ctl_o.sel_cls] - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/tcpq_store.sv
// Tag memory for the three class FIFOs, one write and one registered read port.
`default_nettype none

module tcpq_store #(
  parameter int unsigned QUEUE_DEPTH = 16,
  localparam int unsigned IW = $clog2(QUEUE_DEPTH)
) (
  input  wire logic            clk_i,
  input  wire tcpq_pkg::ctrl_t ctl_i,
  input  wire logic [IW-1:0]   waddr_i,
  input  wire logic [IW-1:0]   raddr_i,
  input  wire logic [31:0]     wdata_i,
  output logic [31:0]          rdata_o
);
  import tcpq_pkg::*;

  logic [31:0] mem_q [ClassCount][QUEUE_DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[ctl_i.sel_cls][waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next dequeue, so a stalled result keeps its tag
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[ctl_i.sel_cls][raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/three_class_priority_queue.sv
// Top level of the three-class strict priority queue.
//
//  channel   dir  handshake                      tdata        tuser (low bit up)
//  s_axis    in   s_axis_tvalid / s_axis_tready  payload_tag  operation, priority_class
//  m_axis    out  m_axis_tvalid / m_axis_tready  served_tag   status, served_class
//
// One request a cycle sustained while m_axis_tready stays high; each request passes
// the input register, then the decision and store read into the result register.
// The rate is set by the single decide stage: counters and the store's one
// write / one read port are touched once per request.
// Reset clears pointers, fill counts and valid flags only; the tag store is not cleared.
// A stalled result holds in the result register while one more request waits in
// the input register; s_axis_tready drops only when both are occupied.
`default_nettype none

module three_class_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] payload_tag
  input  wire logic [2:0]  s_axis_tuser,   // [0] operation, [2:1] priority_class
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] served_tag
  output logic [4:0]       m_axis_tuser    // [2:0] status, [4:3] served_class
);
  import tcpq_pkg::*;

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);

  // input register
  logic        a_valid_q;
  op_e         a_op_q;
  logic [31:0] a_tag_q;
  logic [1:0]  a_cls_q;

  // result register
  logic        b_valid_q;
  status_e     b_status_q;
  class_e      b_cls_q;

  logic          advance;
  ctrl_t         ctl;
  logic [IW-1:0] waddr;
  logic [IW-1:0] raddr;
  logic [31:0]   rd_tag;

  // the input stage moves on when the result slot is free or being drained
  assign advance       = a_valid_q && (!b_valid_q || m_axis_tready);
  assign s_axis_tready = !a_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      a_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      a_op_q  <= op_e'(s_axis_tuser[0]);
      a_cls_q <= s_axis_tuser[2:1];
      a_tag_q <= s_axis_tdata;
    end
  end

  tcpq_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (advance),
    .op_i    (a_op_q),
    .cls_i   (a_cls_q),
    .ctl_o   (ctl),
    .waddr_o (waddr),
    .raddr_o (raddr)
  );

  tcpq_store #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .waddr_i (waddr),
    .raddr_i (raddr),
    .wdata_i (a_tag_q),
    .rdata_o (rd_tag)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (advance) begin
      b_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      b_status_q <= ctl.status;
      b_cls_q    <= (ctl.status == ST_DEQUEUED) ? ctl.sel_cls : CLASS_A;
    end
  end

  // tag is only meaningful on a dequeue; every other status shows zero
  assign m_axis_tvalid = b_valid_q;
  assign m_axis_tdata  = (b_status_q == ST_DEQUEUED) ? rd_tag : '0;
  assign m_axis_tuser  = {b_cls_q, b_status_q};

  // -------------------------------------------------------------------------
  // assertions

  a_store_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl.wr_en && ctl.rd_en))
    else $error("store written and read by the same request");

  a_advance_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("processed request left no result");

  a_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser[2:0] != ST_DEQUEUED)) |->
      ((m_axis_tuser[4:3] == CLASS_A) && (m_axis_tdata == '0)))
    else $error("served fields not cleared on a non-dequeue result");

  a_enable_only_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.wr_en || ctl.rd_en) |-> advance)
    else $error("store touched without a request moving on");

endmodule

`default_nettype wire
